### src/assert_macros.svh
// Assertion macros used by the top level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/dlc_pkg.sv
// Shared types and constants of the distance link constraint core.
package dlc_pkg;
    localparam int RADIUS_WIDTH = 24;
    localparam int TARGET_WIDTH = 31;
    localparam int LANES        = 4;

    typedef struct packed {
        logic valid;
        logic advance;
    } pipe_ctrl_t;
endpackage

### src/dlc_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module dlc_sqrt #(
    parameter int IN_W   = 67,
    parameter int OUT_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dlc_pkg::pipe_ctrl_t ctrl,
    input  logic [IN_W-1:0]    radicand,
    input  logic [SIDE_W-1:0]  side_in,
    output logic               valid_out,
    output logic [OUT_W-1:0]   root,
    output logic [SIDE_W-1:0]  side_out
);

    logic [IN_W-1:0]   rem_reg  [OUT_W];
    logic [OUT_W-1:0]  root_reg [OUT_W];
    logic [SIDE_W-1:0] side_reg [OUT_W];
    logic              vld_reg  [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        localparam int B = OUT_W - 1 - k;
        logic [IN_W-1:0]   rem_prev;
        logic [OUT_W-1:0]  root_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              vld_prev;
        logic [IN_W:0]     trial;
        logic              take;
        logic [IN_W-1:0]   rem_next;
        logic [OUT_W-1:0]  root_next;

        if (k == 0) begin : g_first
            assign rem_prev  = radicand;
            assign root_prev = '0;
            assign side_prev = side_in;
            assign vld_prev  = ctrl.valid;
        end else begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        assign trial = ({{(IN_W + 1 - OUT_W){1'b0}}, root_prev} << (B + 1))
                     + ((IN_W + 1)'(1) << (2 * B));
        assign take      = {1'b0, rem_prev} >= trial;
        assign rem_next  = take ? IN_W'({1'b0, rem_prev} - trial) : rem_prev;
        assign root_next = take ? (root_prev | (OUT_W'(1) << B)) : root_prev;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (ctrl.advance)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.advance)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign valid_out = vld_reg[OUT_W-1];
    assign root      = root_reg[OUT_W-1];
    assign side_out  = side_reg[OUT_W-1];

endmodule

### src/dlc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module dlc_div #(
    parameter int DEN_W  = 58,
    parameter int QUO_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dlc_pkg::pipe_ctrl_t    ctrl,
    input  logic [DEN_W+QUO_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   valid_out,
    output logic [QUO_W-1:0]       quo,
    output logic [SIDE_W-1:0]      side_out
);

    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  low_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic              vld_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - 1 - k;
        logic [DEN_W-1:0]  rem_prev;
        logic [QUO_W-1:0]  low_prev;
        logic [DEN_W-1:0]  den_prev;
        logic [QUO_W-1:0]  quo_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              vld_prev;
        logic [DEN_W:0]    shifted;
        logic              take;
        logic [DEN_W-1:0]  rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (k == 0) begin : g_first
            assign rem_prev  = num[DEN_W+QUO_W-1:QUO_W];
            assign low_prev  = num[QUO_W-1:0];
            assign den_prev  = den;
            assign quo_prev  = '0;
            assign side_prev = side_in;
            assign vld_prev  = ctrl.valid;
        end else begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign low_prev  = low_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        assign shifted  = {rem_prev, low_prev[B]};
        assign take     = shifted >= {1'b0, den_prev};
        assign rem_next = take ? DEN_W'(shifted - {1'b0, den_prev}) : shifted[DEN_W-1:0];
        assign quo_next = take ? (quo_prev | (QUO_W'(1) << B)) : quo_prev;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (ctrl.advance)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.advance)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_prev;
                den_reg[k]  <= den_prev;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign valid_out = vld_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

### src/distance_link_constraint_core.sv
// Distance link constraint core: top level pipeline.
// Usage:
//   Input channel (in_valid / in_stall) takes one link per item: two positions,
//   two radii, two movable flags and a target length. Output channel
//   (out_valid / out_stall) returns the corrected positions and a degenerate
//   flag, one result item per input item, in order.
// Pipeline: an accepted item passes the front-end stages, the root pipeline
//   (one bit per stage), the scaling stages and the four parallel dividers
//   before it reaches out_valid.
// Throughput: one item per cycle unless out_stall holds the pipeline; the whole
//   pipeline moves on a single advance enable.
// Reset: rst_n clears all stage valid bits; no item is in flight afterwards.
// Stall: while out_valid is high and out_stall is high the pipeline holds,
//   the output stays put and in_stall is raised; nothing is lost or repeated.
`include "assert_macros.svh"
module distance_link_constraint_core #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [POSITION_WIDTH-1:0]        first_x,
    input  logic signed [POSITION_WIDTH-1:0]        first_y,
    input  logic signed [POSITION_WIDTH-1:0]        second_x,
    input  logic signed [POSITION_WIDTH-1:0]        second_y,
    input  logic [dlc_pkg::RADIUS_WIDTH-1:0]        first_radius,
    input  logic [dlc_pkg::RADIUS_WIDTH-1:0]        second_radius,
    input  logic                                    first_movable,
    input  logic                                    second_movable,
    input  logic [dlc_pkg::TARGET_WIDTH-1:0]        target_length,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [POSITION_WIDTH-1:0]        new_first_x,
    output logic signed [POSITION_WIDTH-1:0]        new_first_y,
    output logic signed [POSITION_WIDTH-1:0]        new_second_x,
    output logic signed [POSITION_WIDTH-1:0]        new_second_y,
    output logic                                    degenerate
);

    localparam int P    = POSITION_WIDTH;
    localparam int MAGW = P + 1;
    localparam int SQW  = 2 * MAGW;
    localparam int SSW  = SQW + 1;
    localparam int LW   = P + 1;
    localparam int RW   = dlc_pkg::RADIUS_WIDTH + 1;
    localparam int TW   = dlc_pkg::TARGET_WIDTH;
    localparam int QW   = (TW > LW) ? TW : LW;
    localparam int PW   = QW + MAGW;
    localparam int LOW  = PW / 2;
    localparam int HIW  = PW - LOW;
    localparam int NW   = PW + RW;
    localparam int DNW  = NW - QW;
    localparam int SUMW = ((P > QW + 1) ? P : QW + 1) + 1;
    localparam int SIDW = P + 2;
    localparam int L    = dlc_pkg::LANES;

    typedef struct packed {
        logic [3:0][P-1:0]    pos;
        logic [1:0][MAGW-1:0] mag;
        logic [1:0]           sgn;
        logic [RW-1:0]        rsum;
        logic [1:0][RW-1:0]   share;
        logic [TW-1:0]        maxrt;
    } link_t;

    logic adv;
    dlc_pkg::pipe_ctrl_t sq_ctrl;
    dlc_pkg::pipe_ctrl_t dv_ctrl;

    // front end
    logic [P:0]      dx_next, dy_next;
    logic [RW-1:0]   rsum_next;
    link_t           link_next;

    link_t           s1_link_reg, s2_link_reg, s3_link_reg, s4_link_reg, s5_link_reg;
    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [SQW-1:0]  s2_sq_reg [2];
    logic [SSW-1:0]  s3_sum_reg;

    link_t           sq_link;
    logic [$bits(link_t)-1:0] sq_side;
    logic [LW-1:0]   sq_len;
    logic            sq_valid;

    logic [QW:0]     delta_next;
    logic            s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic [QW-1:0]   s4_mdelta_reg;
    logic            s4_sdelta_reg, s5_sdelta_reg;
    logic [DNW-1:0]  s4_den_reg, s5_den_reg, s6_den_reg, s7_den_reg;
    logic            s4_degen_reg, s5_degen_reg, s6_degen_reg, s7_degen_reg;
    logic [PW-1:0]   s5_prod_reg [2];
    logic [LOW+RW-1:0] s6_lo_reg [L];
    logic [HIW+RW-1:0] s6_hi_reg [L];
    logic            s6_neg_reg [L];
    logic [P-1:0]    s6_pos_reg [L];
    logic [NW-1:0]   s7_num_reg [L];
    logic            s7_neg_reg [L];
    logic [P-1:0]    s7_pos_reg [L];

    logic            dv [L];
    logic [QW-1:0]   dq [L];
    logic [SIDW-1:0] dside [L];

    logic            out_valid_reg, out_degen_reg;
    logic [P-1:0]    out_pos_reg [L];

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    assign dx_next   = {first_x[P-1], first_x} - {second_x[P-1], second_x};
    assign dy_next   = {first_y[P-1], first_y} - {second_y[P-1], second_y};
    assign rsum_next = {1'b0, first_radius} + {1'b0, second_radius};

    always_comb
    begin
        link_next.pos[0] = first_x;
        link_next.pos[1] = first_y;
        link_next.pos[2] = second_x;
        link_next.pos[3] = second_y;
        link_next.mag[0] = dx_next[P] ? MAGW'(~dx_next + 1'b1) : MAGW'(dx_next);
        link_next.mag[1] = dy_next[P] ? MAGW'(~dy_next + 1'b1) : MAGW'(dy_next);
        link_next.sgn[0] = dx_next[P];
        link_next.sgn[1] = dy_next[P];
        link_next.rsum   = rsum_next;
        link_next.maxrt  = (TW'(rsum_next) > target_length) ? TW'(rsum_next) : target_length;
        case ({first_movable, second_movable})
            2'b11:
            begin
                link_next.share[0] = RW'(first_radius);
                link_next.share[1] = RW'(second_radius);
            end
            2'b10:
            begin
                link_next.share[0] = rsum_next;
                link_next.share[1] = '0;
            end
            2'b01:
            begin
                link_next.share[0] = '0;
                link_next.share[1] = rsum_next;
            end
            default:
            begin
                link_next.share[0] = '0;
                link_next.share[1] = '0;
            end
        endcase
    end

    assign delta_next = (QW + 1)'(sq_link.maxrt) - (QW + 1)'(sq_len);

    assign sq_ctrl.valid   = s3_valid_reg;
    assign sq_ctrl.advance = adv;
    assign sq_link         = link_t'(sq_side);

    dlc_sqrt #(
        .IN_W   (SSW),
        .OUT_W  (LW),
        .SIDE_W ($bits(link_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sq_ctrl),
        .radicand  (s3_sum_reg),
        .side_in   (s3_link_reg),
        .valid_out (sq_valid),
        .root      (sq_len),
        .side_out  (sq_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= sq_valid;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            out_valid_reg <= dv[0] & dv[1] & dv[2] & dv[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_link_reg  <= link_next;

            s2_link_reg  <= s1_link_reg;
            s2_sq_reg[0] <= s1_link_reg.mag[0] * s1_link_reg.mag[0];
            s2_sq_reg[1] <= s1_link_reg.mag[1] * s1_link_reg.mag[1];

            s3_link_reg  <= s2_link_reg;
            s3_sum_reg   <= {1'b0, s2_sq_reg[0]} + {1'b0, s2_sq_reg[1]};

            s4_link_reg   <= sq_link;
            s4_sdelta_reg <= delta_next[QW];
            s4_mdelta_reg <= delta_next[QW] ? QW'(~delta_next + 1'b1) : QW'(delta_next);
            s4_den_reg    <= DNW'(sq_len * sq_link.rsum);
            s4_degen_reg  <= (sq_len == '0) || (sq_link.rsum == '0);

            s5_link_reg    <= s4_link_reg;
            s5_sdelta_reg  <= s4_sdelta_reg;
            s5_den_reg     <= s4_den_reg;
            s5_degen_reg   <= s4_degen_reg;
            s5_prod_reg[0] <= PW'(s4_mdelta_reg * s4_link_reg.mag[0]);
            s5_prod_reg[1] <= PW'(s4_mdelta_reg * s4_link_reg.mag[1]);

            s6_den_reg   <= s5_den_reg;
            s6_degen_reg <= s5_degen_reg;
            for (int i = 0; i < L; i++)
            begin
                s6_lo_reg[i]  <= (LOW + RW)'(s5_prod_reg[i % 2][LOW-1:0]
                                 * s5_link_reg.share[i / 2]);
                s6_hi_reg[i]  <= (HIW + RW)'(s5_prod_reg[i % 2][PW-1:LOW]
                                 * s5_link_reg.share[i / 2]);
                s6_neg_reg[i] <= s5_sdelta_reg ^ s5_link_reg.sgn[i % 2] ^ (i >= 2);
                s6_pos_reg[i] <= s5_link_reg.pos[i];
            end

            s7_den_reg   <= s6_den_reg;
            s7_degen_reg <= s6_degen_reg;
            for (int i = 0; i < L; i++)
            begin
                s7_num_reg[i] <= ({{(NW - HIW - RW){1'b0}}, s6_hi_reg[i]} << LOW)
                               + NW'(s6_lo_reg[i]);
                s7_neg_reg[i] <= s6_neg_reg[i];
                s7_pos_reg[i] <= s6_pos_reg[i];
            end
        end
    end

    assign dv_ctrl.valid   = s7_valid_reg;
    assign dv_ctrl.advance = adv;

    for (genvar i = 0; i < L; i++) begin : g_lane
        dlc_div #(
            .DEN_W  (DNW),
            .QUO_W  (QW),
            .SIDE_W (SIDW)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (dv_ctrl),
            .num       (s7_num_reg[i]),
            .den       (s7_den_reg),
            .side_in   ({s7_pos_reg[i], s7_neg_reg[i], s7_degen_reg}),
            .valid_out (dv[i]),
            .quo       (dq[i]),
            .side_out  (dside[i])
        );
    end

    logic [SUMW-1:0] corr_next [L];
    logic [SUMW-1:0] sum_next  [L];
    logic [P-1:0]    sat_next  [L];

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            corr_next[i] = dside[i][1] ? SUMW'(~SUMW'(dq[i]) + 1'b1) : SUMW'(dq[i]);
            sum_next[i]  = {{(SUMW - P){dside[i][P+1]}}, dside[i][P+1:2]} + corr_next[i];
            if (sum_next[i][SUMW-1:P-1] == '0 || sum_next[i][SUMW-1:P-1] == '1)
            begin
                sat_next[i] = sum_next[i][P-1:0];
            end
            else if (sum_next[i][SUMW-1])
            begin
                sat_next[i] = {1'b1, {(P - 1){1'b0}}};
            end
            else
            begin
                sat_next[i] = {1'b0, {(P - 1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_degen_reg <= dside[0][0];
            for (int i = 0; i < L; i++)
            begin
                out_pos_reg[i] <= dside[i][0] ? dside[i][P+1:2] : sat_next[i];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign degenerate   = out_degen_reg;
    assign new_first_x  = out_pos_reg[0];
    assign new_first_y  = out_pos_reg[1];
    assign new_second_x = out_pos_reg[2];
    assign new_second_y = out_pos_reg[3];

    `ASSERT_ALWAYS(a_lanes_agree, clk, rst_n, (dv[0] == dv[1]) && (dv[1] == dv[2]) && (dv[2] == dv[3]))
    `ASSERT_IMPLY(a_degen_den, clk, rst_n, s4_valid_reg && s4_degen_reg, s4_den_reg == '0)
    `ASSERT_NEXT(a_take_in, clk, rst_n, in_valid && !in_stall, s1_valid_reg)

endmodule
